/* rtl/sbw_pkg.sv */
`default_nettype none

package sbw_pkg;

	// Fixed field widths of the channels and the configuration port.
	localparam int TIME_W      = 32;
	localparam int RATE_W      = 32;
	localparam int DRIVE_W     = 18;
	localparam int CFG_DATA_W  = 64;
	localparam int REG_IDX_W   = 3;
	localparam int COUNT_W     = 3;
	localparam int FIELD_W     = 16;
	localparam int NUM_FIELDS  = 4;
	localparam int WIN_IDX_W   = 2;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_CYCLE_RATE     = 3'd0,
		REG_ACTIVE_WINDOWS = 3'd1,
		REG_WINDOW_STARTS  = 3'd2,
		REG_WINDOW_WIDTHS  = 3'd3,
		REG_WINDOW_HEIGHTS = 3'd4
	} sbw_reg_t;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_SCAN
	} sbw_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 load_phase;
		logic                 acc_en;
		logic                 load_out;
		logic [WIN_IDX_W-1:0] win_idx;
	} sbw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [COUNT_W-1:0] win_count;
	} sbw_status_t;

endpackage

`default_nettype wire

/* rtl/sbw_if.sv */
`default_nettype none

// Input channel: one time value per beat.
interface sbw_time_if;
	logic                          valid;
	logic                          ready;
	logic [sbw_pkg::TIME_W-1:0]    sim_time;

	modport source (output valid, output sim_time, input ready);
	modport sink   (input valid, input sim_time, output ready);
endinterface

// Output channel: one drive value per beat.
interface sbw_drive_if;
	logic                              valid;
	logic                              ready;
	logic signed [sbw_pkg::DRIVE_W-1:0] drive_value;

	modport source (output valid, output drive_value, input ready);
	modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

/* rtl/sbw_ctrl.sv */
`default_nettype none

module sbw_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire sbw_pkg::sbw_status_t status,
	output sbw_pkg::sbw_cmd_t        cmd
);

	sbw_pkg::sbw_state_t               state_q, state_d;
	logic [sbw_pkg::WIN_IDX_W-1:0]     cnt_q, cnt_d;
	logic [sbw_pkg::WIN_IDX_W-1:0]     last_idx;
	logic [sbw_pkg::COUNT_W-1:0]       count_m1;
	logic                              out_valid_q;
	logic                              out_free;
	logic                              last;

	// At least one sweep step runs, so an empty stack still yields a zero result.
	assign count_m1 = status.win_count - sbw_pkg::COUNT_W'(1);
	assign last_idx = (status.win_count == '0) ? '0 : count_m1[sbw_pkg::WIN_IDX_W-1:0];
	assign last     = (cnt_q == last_idx);
	assign out_free = !out_valid_q || out_ready;

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		cmd.load_phase = 1'b0;
		cmd.acc_en     = 1'b0;
		cmd.load_out   = 1'b0;
		cmd.win_idx    = cnt_q;
		in_ready       = 1'b0;
		case (state_q)
			sbw_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_phase = 1'b1;
					cnt_d          = '0;
					state_d        = sbw_pkg::S_SCAN;
				end
			end
			sbw_pkg::S_SCAN: begin
				if (!last) begin
					cmd.acc_en = 1'b1;
					cnt_d      = cnt_q + sbw_pkg::WIN_IDX_W'(1);
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					cnt_d        = '0;
					state_d      = sbw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sbw_pkg::S_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// State, sweep counter and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbw_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/sbw_datapath.sv */
`default_nettype none

module sbw_datapath #(
	parameter int STACK_DEPTH = 4,
	parameter int PHASE_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [sbw_pkg::REG_IDX_W-1:0]       wr_index,
	input  wire logic [sbw_pkg::CFG_DATA_W-1:0]      wr_data,
	input  wire logic [sbw_pkg::TIME_W-1:0]          sim_time,
	input  wire sbw_pkg::sbw_cmd_t                   cmd,
	output sbw_pkg::sbw_status_t                     status,
	output logic signed [sbw_pkg::DRIVE_W-1:0]       drive_value
);

	logic [sbw_pkg::RATE_W-1:0]                     cycle_rate_q;
	logic [sbw_pkg::COUNT_W-1:0]                    active_q;
	logic [sbw_pkg::CFG_DATA_W-1:0]                 starts_q;
	logic [sbw_pkg::CFG_DATA_W-1:0]                 widths_q;
	logic [sbw_pkg::CFG_DATA_W-1:0]                 heights_q;

	logic [sbw_pkg::TIME_W-1:0]                     phase_full;
	logic [PHASE_BITS-1:0]                          phase_q;
	logic signed [sbw_pkg::DRIVE_W-1:0]             acc_q;
	logic signed [sbw_pkg::DRIVE_W-1:0]             acc_next;
	logic signed [sbw_pkg::DRIVE_W-1:0]             drive_q;

	logic [sbw_pkg::FIELD_W-1:0]                    start_f, width_f, height_f;
	logic [PHASE_BITS-1:0]                          win_s, win_w;
	logic [PHASE_BITS:0]                            win_e;
	logic                                           hit;
	logic                                           in_use;
	logic signed [sbw_pkg::DRIVE_W-1:0]             contrib;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_rate_q <= '0;
			active_q     <= '0;
			starts_q     <= '0;
			widths_q     <= '0;
			heights_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				sbw_pkg::REG_CYCLE_RATE:     cycle_rate_q <= wr_data[sbw_pkg::RATE_W-1:0];
				sbw_pkg::REG_ACTIVE_WINDOWS: active_q     <= wr_data[sbw_pkg::COUNT_W-1:0];
				sbw_pkg::REG_WINDOW_STARTS:  starts_q     <= wr_data;
				sbw_pkg::REG_WINDOW_WIDTHS:  widths_q     <= wr_data;
				sbw_pkg::REG_WINDOW_HEIGHTS: heights_q    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Window count, clamped to the stack depth.
	assign status.win_count = (active_q > sbw_pkg::COUNT_W'(STACK_DEPTH))
		? sbw_pkg::COUNT_W'(STACK_DEPTH) : active_q;

	// Phase: low product bits, of which the top PHASE_BITS are compared.
	assign phase_full = sbw_pkg::TIME_W'(sim_time * cycle_rate_q);

	// Select the window under test.
	assign start_f  = starts_q[cmd.win_idx*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W];
	assign width_f  = widths_q[cmd.win_idx*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W];
	assign height_f = heights_q[cmd.win_idx*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W];
	assign win_s    = start_f[sbw_pkg::FIELD_W-1 -: PHASE_BITS];
	assign win_w    = width_f[sbw_pkg::FIELD_W-1 -: PHASE_BITS];
	assign win_e    = {1'b0, win_s} + {1'b0, win_w};

	// Open-interval test; a window whose end runs past the end of the phase cycle wraps.
	always_comb begin
		if (!win_e[PHASE_BITS]) begin
			hit = (phase_q > win_s) && ({1'b0, phase_q} < win_e);
		end else begin
			hit = (phase_q < win_e[PHASE_BITS-1:0]) || (phase_q > win_s);
		end
	end

	assign in_use   = ({1'b0, cmd.win_idx} < status.win_count);
	assign contrib  = (hit && in_use)
		? sbw_pkg::DRIVE_W'($signed(height_f)) : '0;
	assign acc_next = acc_q + contrib;

	// Phase, accumulator and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load_phase) begin
			phase_q <= phase_full[sbw_pkg::TIME_W-1 -: PHASE_BITS];
			acc_q   <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_next;
		end
		if (cmd.load_out) begin
			drive_q <= acc_next;
		end
	end

	assign drive_value = drive_q;

endmodule

`default_nettype wire

/* rtl/stacked_boxcar_waveform.sv */
`default_nettype none

// Stacked boxcar waveform generator. Each time beat is multiplied by cycle_rate; the low
// 32 product bits are the cycle phase, of which the top PHASE_BITS are compared against
// up to STACK_DEPTH windows (start, width, signed height; a window running past the end
// of the cycle wraps). The result beat carries the sum of the heights of all windows
// whose open interval holds the phase. The multiply is registered as the time beat is
// taken, then one window is tested per cycle by a single shared compare unit (the last
// one waits while the output register is full); max(N, 1) windows are swept, N being
// active_windows clamped to STACK_DEPTH. A finished result waits in an output register
// while the next time beat is taken. Configuration writes belong to idle periods.
module stacked_boxcar_waveform #(
	parameter int STACK_DEPTH = 4,
	parameter int PHASE_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [sbw_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [sbw_pkg::CFG_DATA_W-1:0] wr_data,
	sbw_time_if.sink                            time_in,
	sbw_drive_if.source                         drive_out
);

	sbw_pkg::sbw_cmd_t    cmd;
	sbw_pkg::sbw_status_t status;

	// Sequencer.
	sbw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (time_in.valid),
		.in_ready  (time_in.ready),
		.out_valid (drive_out.valid),
		.out_ready (drive_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Registers, multiplier, window compare and accumulator.
	sbw_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.PHASE_BITS  (PHASE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.sim_time    (time_in.sim_time),
		.cmd         (cmd),
		.status      (status),
		.drive_value (drive_out.drive_value)
	);

`ifndef SYNTH
	// Only one item is in flight: a taken beat closes the input for the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(time_in.valid && time_in.ready) |=> !time_in.ready)
		else $error("input taken while an item is in flight");

	// The result register is loaded only when its previous beat is gone or leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!drive_out.valid || drive_out.ready))
		else $error("pending result overwritten");

	// The clamped window count never exceeds the stack depth.
	a_count_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		status.win_count <= sbw_pkg::COUNT_W'(STACK_DEPTH))
		else $error("window count above stack depth");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH   = 4;
	localparam int PHASE_BITS    = 16;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int HOLD_CYCLES   = 400;
	localparam int FIRST_UNUSED_REG = int'(sbw_pkg::REG_WINDOW_HEIGHTS) + 1;

	typedef logic signed [sbw_pkg::DRIVE_W-1:0] drive_t;

	typedef enum {ROW_WRITE, ROW_TIME} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [sbw_pkg::REG_IDX_W-1:0]   index;
		logic [sbw_pkg::CFG_DATA_W-1:0]  data;
		logic [sbw_pkg::TIME_W-1:0]      sim_time;
		bit                              known;
		drive_t                          value;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [sbw_pkg::REG_IDX_W-1:0] wr_index;
	logic [sbw_pkg::CFG_DATA_W-1:0] wr_data;

	sbw_time_if  time_ch ();
	sbw_drive_if drive_ch ();

	stacked_boxcar_waveform #(
		.STACK_DEPTH (STACK_DEPTH),
		.PHASE_BITS  (PHASE_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.time_in   (time_ch),
		.drive_out (drive_ch)
	);

	// Shadow copy of the configuration registers.
	logic [sbw_pkg::RATE_W-1:0]     rate_cfg;
	logic [sbw_pkg::COUNT_W-1:0]    windows_cfg;
	logic [sbw_pkg::CFG_DATA_W-1:0] starts_cfg;
	logic [sbw_pkg::CFG_DATA_W-1:0] widths_cfg;
	logic [sbw_pkg::CFG_DATA_W-1:0] heights_cfg;

	drive_t    drive_expected [$];
	stim_row_t stim_rows [$];
	int        error_count;
	int        src_idle_pct;
	int        sink_idle_pct;
	int        hold_request;
	int        hold_left;

	// Free-running clock.
	always #6 clk = ~clk;

	// Sum of the heights of every window whose open interval holds the phase of t.
	function automatic drive_t drive_for_time(logic [sbw_pkg::TIME_W-1:0] t);
		logic [63:0]         product;
		logic [31:0]         phase;
		logic [PHASE_BITS:0] p;
		logic [PHASE_BITS:0] s;
		logic [PHASE_BITS:0] w;
		logic [PHASE_BITS:0] e;
		logic [PHASE_BITS:0] one;
		logic signed [sbw_pkg::FIELD_W-1:0] h;
		int     n;
		bit     hit;
		drive_t sum;
		product = {32'd0, t} * {32'd0, rate_cfg};
		phase = product[31:0];
		p = (PHASE_BITS+1)'(phase >> (32 - PHASE_BITS));
		one = (PHASE_BITS+1)'(1) << PHASE_BITS;
		n = (windows_cfg > sbw_pkg::COUNT_W'(STACK_DEPTH)) ? STACK_DEPTH : int'(windows_cfg);
		sum = '0;
		for (int i = 0; i < n; i++) begin
			s = (PHASE_BITS+1)'(starts_cfg[i*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W]
				>> (sbw_pkg::FIELD_W - PHASE_BITS));
			w = (PHASE_BITS+1)'(widths_cfg[i*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W]
				>> (sbw_pkg::FIELD_W - PHASE_BITS));
			e = s + w;
			if (e < one) begin
				hit = (p > s) && (p < e);
			end else begin
				hit = (p < e - one) || (p > s);
			end
			h = heights_cfg[i*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W];
			if (hit) begin
				sum = sum + h;
			end
		end
		return sum;
	endfunction

	// Directed table builders.
	function automatic void add_write(int index, logic [sbw_pkg::CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{kind: ROW_WRITE, index: sbw_pkg::REG_IDX_W'(index), data: data,
			sim_time: '0, known: 0, value: '0};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_time(logic [sbw_pkg::TIME_W-1:0] t);
		stim_row_t row;
		row = '{kind: ROW_TIME, index: '0, data: '0, sim_time: t, known: 0, value: '0};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_known(logic [sbw_pkg::TIME_W-1:0] t, int value);
		stim_row_t row;
		row = '{kind: ROW_TIME, index: '0, data: '0, sim_time: t, known: 1,
			value: sbw_pkg::DRIVE_W'(value)};
		stim_rows.push_back(row);
	endfunction

	// Corner-heavy 16-bit field.
	function automatic logic [sbw_pkg::FIELD_W-1:0] pick_field();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return sbw_pkg::FIELD_W'($urandom());
		endcase
	endfunction

	// One register write, mirrored into the shadow copy.
	task automatic write_reg(logic [sbw_pkg::REG_IDX_W-1:0] index,
		logic [sbw_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = index;
		wr_data = data;
		@(negedge clk);
		wr_en = 1'b0;
		case (index)
			sbw_pkg::REG_CYCLE_RATE:     rate_cfg = data[sbw_pkg::RATE_W-1:0];
			sbw_pkg::REG_ACTIVE_WINDOWS: windows_cfg = data[sbw_pkg::COUNT_W-1:0];
			sbw_pkg::REG_WINDOW_STARTS:  starts_cfg = data;
			sbw_pkg::REG_WINDOW_WIDTHS:  widths_cfg = data;
			sbw_pkg::REG_WINDOW_HEIGHTS: heights_cfg = data;
			default: ;
		endcase
	endtask

	// Stop offering beats and wait for every expected result, then let the block settle.
	task automatic wait_drained();
		@(negedge clk);
		time_ch.valid = 1'b0;
		while (drive_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one time beat after a random gap and record its expected result on acceptance.
	task automatic send_time(logic [sbw_pkg::TIME_W-1:0] t, bit known, drive_t value);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			time_ch.valid = 1'b0;
			@(negedge clk);
		end
		time_ch.valid = 1'b1;
		time_ch.sim_time = t;
		do begin
			@(posedge clk);
		end while (!time_ch.ready);
		drive_expected.push_back(known ? value : drive_for_time(t));
	endtask

	// Receiver: random back-pressure, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			drive_ch.ready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			drive_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Result checker: every accepted beat against the oldest expectation.
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (drive_expected.size() == 0) begin
				$error("drive_value beat with no expectation: actual %0d", drive_ch.drive_value);
				error_count = error_count + 1;
			end else begin
				want = drive_expected.pop_front();
				if (drive_ch.drive_value !== want) begin
					$error("drive_value mismatch: expected %0d, actual %0d",
						want, drive_ch.drive_value);
					error_count = error_count + 1;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Main sequence.
	initial begin
		stim_row_t row;
		int random_sent;
		int phase_items;
		int pause_at;
		int win;
		bit pressure_done;
		logic [sbw_pkg::FIELD_W-1:0] edge_p;
		logic [sbw_pkg::FIELD_W-1:0] s16;
		logic [sbw_pkg::FIELD_W-1:0] e16;
		logic [31:0] noise;
		logic [sbw_pkg::TIME_W-1:0] t;

		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		time_ch.valid = 1'b0;
		time_ch.sim_time = '0;
		drive_ch.ready = 1'b0;
		rate_cfg = '0;
		windows_cfg = '0;
		starts_cfg = '0;
		widths_cfg = '0;
		heights_cfg = '0;
		error_count = 0;
		hold_request = 0;
		hold_left = 0;
		src_idle_pct = 17;
		sink_idle_pct = 81;
		random_sent = 0;
		pressure_done = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// After reset: zero rate and no windows.
		add_known(32'h0000_0000, 0);
		add_known(32'hFFFF_FFFF, 0);
		// Unit rate, so the phase is the time itself; one window with open bounds.
		add_write(sbw_pkg::REG_CYCLE_RATE, 64'd1);
		add_write(sbw_pkg::REG_WINDOW_STARTS, 64'hFFFF_0000_F000_1000);
		add_write(sbw_pkg::REG_WINDOW_WIDTHS, 64'hFFFF_FFFF_2000_1000);
		add_write(sbw_pkg::REG_WINDOW_HEIGHTS, 64'hFFFF_0001_8000_7FFF);
		add_write(sbw_pkg::REG_ACTIVE_WINDOWS, 64'd1);
		add_known(32'h1000_0000, 0);
		add_known(32'h1001_0000, 32767);
		add_known(32'h1FFF_FFFF, 32767);
		add_known(32'h2000_0000, 0);
		// All four windows, including ones that wrap around the cycle.
		add_write(sbw_pkg::REG_ACTIVE_WINDOWS, 64'd4);
		add_time(32'h0000_0000);
		add_time(32'h0FFF_0000);
		add_time(32'h1800_0000);
		add_time(32'hF800_0000);
		add_time(32'hFFFF_FFFF);
		// Window count above the stack depth is clamped.
		add_write(sbw_pkg::REG_ACTIVE_WINDOWS, 64'd7);
		add_time(32'h1800_0000);
		// Writes to unused register indexes change nothing.
		add_write(FIRST_UNUSED_REG, '1);
		add_write(FIRST_UNUSED_REG + 1, '1);
		add_write(FIRST_UNUSED_REG + 2, '1);
		add_time(32'h1800_0000);
		// Largest rate: product truncation.
		add_write(sbw_pkg::REG_CYCLE_RATE, 64'hFFFF_FFFF);
		add_time(32'h0000_0001);
		add_time(32'hFFFF_FFFF);
		// Extremes of the sum: four full-width windows at the most negative height.
		add_write(sbw_pkg::REG_CYCLE_RATE, 64'd1);
		add_write(sbw_pkg::REG_WINDOW_STARTS, 64'h0000_0000_0000_0000);
		add_write(sbw_pkg::REG_WINDOW_WIDTHS, 64'hFFFF_FFFF_FFFF_FFFF);
		add_write(sbw_pkg::REG_WINDOW_HEIGHTS, 64'h8000_8000_8000_8000);
		add_write(sbw_pkg::REG_ACTIVE_WINDOWS, 64'd4);
		add_known(32'h8000_0000, -131072);
		add_write(sbw_pkg::REG_WINDOW_HEIGHTS, 64'h7FFF_7FFF_7FFF_7FFF);
		add_known(32'h8000_0000, 131068);
		// No windows in use.
		add_write(sbw_pkg::REG_ACTIVE_WINDOWS, 64'd0);
		add_known(32'h8000_0000, 0);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_WRITE) begin
				wait_drained();
				write_reg(row.index, row.data);
			end else begin
				send_time(row.sim_time, row.known, row.value);
			end
		end

		// Random phases: a fresh configuration, then a burst of time beats.
		while (random_sent < RANDOM_ITEMS) begin
			wait_drained();
			if (random_sent < RANDOM_ITEMS / 3) begin
				src_idle_pct = 17;
				sink_idle_pct = 81;
			end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 81;
				sink_idle_pct = 17;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end

			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 9))
					0: write_reg(sbw_pkg::REG_CYCLE_RATE, 64'd0);
					1: write_reg(sbw_pkg::REG_CYCLE_RATE, 64'hFFFF_FFFF);
					2: write_reg(sbw_pkg::REG_CYCLE_RATE, 64'($urandom_range(2, 255)));
					3, 4: write_reg(sbw_pkg::REG_CYCLE_RATE, 64'($urandom()));
					default: write_reg(sbw_pkg::REG_CYCLE_RATE, 64'd1);
				endcase
			end
			if ($urandom_range(0, 4) != 0) begin
				write_reg(sbw_pkg::REG_ACTIVE_WINDOWS, 64'($urandom_range(0, 7)));
			end
			if ($urandom_range(0, 4) != 0) begin
				write_reg(sbw_pkg::REG_WINDOW_STARTS,
					{pick_field(), pick_field(), pick_field(), pick_field()});
			end
			if ($urandom_range(0, 4) != 0) begin
				write_reg(sbw_pkg::REG_WINDOW_WIDTHS,
					{pick_field(), pick_field(), pick_field(), pick_field()});
			end
			if ($urandom_range(0, 4) != 0) begin
				write_reg(sbw_pkg::REG_WINDOW_HEIGHTS,
					{pick_field(), pick_field(), pick_field(), pick_field()});
			end

			phase_items = $urandom_range(20, 80);
			pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, phase_items - 1) : -1;

			// Long receiver hold-off while the sender keeps offering beats.
			if (!pressure_done && src_idle_pct == 0) begin
				hold_request = HOLD_CYCLES;
				pressure_done = 1;
			end

			for (int k = 0; k < phase_items; k++) begin
				noise = $urandom();
				t = $urandom();
				// With unit rate, land the phase right on or beside a window edge.
				if (rate_cfg == 1 && $urandom_range(0, 1) == 0) begin
					win = $urandom_range(0, sbw_pkg::NUM_FIELDS - 1);
					s16 = starts_cfg[win*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W];
					e16 = s16 + widths_cfg[win*sbw_pkg::FIELD_W +: sbw_pkg::FIELD_W];
					case ($urandom_range(0, 5))
						0: edge_p = s16 - 16'd1;
						1: edge_p = s16;
						2: edge_p = s16 + 16'd1;
						3: edge_p = e16 - 16'd1;
						4: edge_p = e16;
						default: edge_p = e16 + 16'd1;
					endcase
					t = {edge_p, noise[sbw_pkg::FIELD_W-1:0]};
				end
				if (k == pause_at) begin
					wait_drained();
				end
				send_time(t, 0, '0);
				random_sent = random_sent + 1;
			end
		end

		// Drain and watch for stray beats.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
